FILE: hw/rtl/hex_cell_center_locator_unit_macros.svh
// assertion macros shared by the hexagon locator rtl
`ifndef HEX_CELL_CENTER_LOCATOR_UNIT_MACROS_SVH
`define HEX_CELL_CENTER_LOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hcl_pkg.sv
// shared types, constants and width helpers of the hexagon locator
`timescale 1ns / 1ps
`default_nettype none

package hcl_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int PITCH_BITS    = 23;
    localparam int INV_BITS      = 16;
    localparam int SQ_BITS       = 48;
    localparam int INDEX_BITS    = 16;
    localparam int DIST_BITS     = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COLUMN_PITCH       = 3'd0,
        CFG_ROW_PITCH          = 3'd1,
        CFG_INV_TILE_WIDTH     = 3'd2,
        CFG_INV_TILE_HEIGHT    = 3'd3,
        CFG_HALF_DOMAIN_WIDTH  = 3'd4,
        CFG_HALF_DOMAIN_HEIGHT = 3'd5,
        CFG_SIZE_SQUARED       = 3'd6
    } hcl_cfg_idx_t;

    // mesh setup as held in the register file
    typedef struct packed {
        logic [PITCH_BITS-1:0] column_pitch;
        logic [PITCH_BITS-1:0] row_pitch;
        logic [INV_BITS-1:0]   inv_tile_width;
        logic [INV_BITS-1:0]   inv_tile_height;
        logic [PITCH_BITS-1:0] half_domain_width;
        logic [PITCH_BITS-1:0] half_domain_height;
        logic [SQ_BITS-1:0]    size_squared;
    } hcl_cfg_t;

    // width of point minus origin
    function automatic int diff_width(int coord_bits);
        return ((coord_bits > PITCH_BITS + 1) ? coord_bits : PITCH_BITS + 1) + 1;
    endfunction

    // width of the unsaturated cell index
    function automatic int idx_width(int coord_bits, int frac_bits);
        return diff_width(coord_bits) + 3 - frac_bits;
    endfunction

    // width of the unsaturated center coordinate
    function automatic int ctr_width(int coord_bits, int frac_bits);
        return idx_width(coord_bits, frac_bits) + PITCH_BITS + 2;
    endfunction

    // width of center minus point
    function automatic int delta_width(int coord_bits, int frac_bits);
        return ctr_width(coord_bits, frac_bits) + 1;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hcl_tile.sv
// offset, tile scaling and hexagon classification, three stages
`timescale 1ns / 1ps
`default_nettype none
`include "hex_cell_center_locator_unit_macros.svh"

module hcl_tile #(
    parameter int COORD_BITS = hcl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hcl_pkg::FRAC_BITS_DEF,
    localparam int IW = hcl_pkg::idx_width(COORD_BITS, FRAC_BITS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcl_pkg::hcl_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [IW-1:0]          icol,
    output logic signed [IW-1:0]          irow,
    output logic signed [COORD_BITS-1:0]  px,
    output logic signed [COORD_BITS-1:0]  py
);
    import hcl_pkg::*;

    localparam int STAGES = 3;
    localparam int DW     = diff_width(COORD_BITS);
    localparam int TFRAC  = FRAC_BITS + INV_BITS;
    localparam int TW     = DW + INV_BITS + 1;
    localparam int KW     = TW - TFRAC;
    localparam int LW     = TFRAC + 3;

    logic [STAGES-1:0] v_reg, v_next, adv;

    logic signed [DW-1:0]         dx_reg, dy_reg, dx_next, dy_next;
    logic signed [TW-1:0]         tx_reg, ty_reg, tx_next, ty_next;
    logic signed [COORD_BITS-1:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic signed [IW-1:0]         icol_reg, irow_reg, icol_next, irow_next;

    logic [KW-1:0] kx, ky;
    logic [LW-1:0] fx, fy, fy3, one;
    logic [1:0]    col_add, row_add;

    // bubble-collapsing advance chain
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[k-1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 1: offset from mesh origin
    always_comb
    begin
        dx_next = DW'(point_x) - $signed(DW'(cfg.half_domain_width));
        dy_next = DW'(point_y) - $signed(DW'(cfg.half_domain_height));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            px1_reg <= point_x;
            py1_reg <= point_y;
        end
    end

    // stage 2: scale into tile units
    always_comb
    begin
        tx_next = TW'(dx_reg) * TW'($signed({1'b0, cfg.inv_tile_width}));
        ty_next = TW'(dy_reg) * TW'($signed({1'b0, cfg.inv_tile_height}));
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // stage 3: floor and fraction, line tests pick the center
    always_comb
    begin
        kx  = tx_reg[TW-1:TFRAC];
        ky  = ty_reg[TW-1:TFRAC];
        fx  = LW'(tx_reg[TFRAC-1:0]);
        fy  = LW'(ty_reg[TFRAC-1:0]);
        fy3 = (fy << 1) + fy;
        one = LW'(1) << TFRAC;
        if (fx <= (one >> 1))
        begin
            if (fx + fy3 <= one)
            begin
                col_add = 2'd0;
                row_add = 2'd0;
            end
            else if (fy3 <= (one << 1) + fx)
            begin
                col_add = 2'd1;
                row_add = 2'd1;
            end
            else
            begin
                col_add = 2'd0;
                row_add = 2'd2;
            end
        end
        else
        begin
            if (fy3 <= fx)
            begin
                col_add = 2'd2;
                row_add = 2'd0;
            end
            else if (fx + fy3 <= (one << 1) + one)
            begin
                col_add = 2'd1;
                row_add = 2'd1;
            end
            else
            begin
                col_add = 2'd2;
                row_add = 2'd2;
            end
        end
        icol_next = $signed({kx[KW-1], kx, 1'b0} + IW'(col_add));
        irow_next = $signed({ky[KW-1], ky, 1'b0} + IW'(row_add));
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            icol_reg <= icol_next;
            irow_reg <= irow_next;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];
    assign icol      = icol_reg;
    assign irow      = irow_reg;
    assign px        = px3_reg;
    assign py        = py3_reg;

    `HCL_ASSERT_NOW(a_tile_full_on_stall, !in_ready, &v_reg, "tile stalls with a bubble inside")
    `HCL_ASSERT_NOW(a_tile_parity, v_reg[2], icol_reg[0] == irow_reg[0],
        "cell column and row parity differ")
    `HCL_ASSERT_NEXT(a_tile_hold, v_reg[2] && !out_ready,
        v_reg[2] && $stable(icol_reg) && $stable(irow_reg), "tile result lost in stall")

endmodule

`default_nettype wire

FILE: hw/rtl/hcl_center.sv
// cell center computation and saturation, two stages
`timescale 1ns / 1ps
`default_nettype none

module hcl_center #(
    parameter int COORD_BITS = hcl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hcl_pkg::FRAC_BITS_DEF,
    localparam int IW  = hcl_pkg::idx_width(COORD_BITS, FRAC_BITS),
    localparam int DXW = hcl_pkg::delta_width(COORD_BITS, FRAC_BITS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hcl_pkg::hcl_cfg_t                    cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [IW-1:0]                 icol,
    input  logic signed [IW-1:0]                 irow,
    input  logic signed [COORD_BITS-1:0]         px,
    input  logic signed [COORD_BITS-1:0]         py,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hcl_pkg::INDEX_BITS-1:0] col_sat,
    output logic signed [hcl_pkg::INDEX_BITS-1:0] row_sat,
    output logic signed [COORD_BITS-1:0]         cx_sat,
    output logic signed [COORD_BITS-1:0]         cy_sat,
    output logic signed [DXW-1:0]                dx,
    output logic signed [DXW-1:0]                dy
);
    import hcl_pkg::*;

    localparam int STAGES = 2;
    localparam int CW     = ctr_width(COORD_BITS, FRAC_BITS);
    localparam int SW     = (IW > INDEX_BITS) ? IW : INDEX_BITS + 1;

    logic [STAGES-1:0] v_reg, v_next, adv;

    logic signed [CW-1:0]         cx_reg, cy_reg, cx_next, cy_next;
    logic signed [COORD_BITS-1:0] px1_reg, py1_reg;
    logic signed [INDEX_BITS-1:0] col1_reg, row1_reg, col_next, row_next;
    logic signed [INDEX_BITS-1:0] col2_reg, row2_reg;
    logic signed [COORD_BITS-1:0] cxs_reg, cys_reg, cxs_next, cys_next;
    logic signed [DXW-1:0]        dx_reg, dy_reg, dx_next, dy_next;
    logic signed [SW-1:0]         col_ext, row_ext;
    logic                         col_ovf, row_ovf, cx_ovf, cy_ovf;

    // bubble-collapsing advance chain
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[k-1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 1: center from index and pitch, index saturation
    always_comb
    begin
        cx_next = CW'(icol) * CW'($signed({1'b0, cfg.column_pitch}))
                + $signed(CW'(cfg.half_domain_width));
        cy_next = CW'(irow) * CW'($signed({1'b0, cfg.row_pitch}))
                + $signed(CW'(cfg.half_domain_height));
        col_ext = SW'(icol);
        row_ext = SW'(irow);
        col_ovf = col_ext[SW-1:INDEX_BITS-1] != {(SW-INDEX_BITS+1){col_ext[SW-1]}};
        row_ovf = row_ext[SW-1:INDEX_BITS-1] != {(SW-INDEX_BITS+1){row_ext[SW-1]}};
        if (col_ovf)
        begin
            col_next = {col_ext[SW-1], {(INDEX_BITS-1){!col_ext[SW-1]}}};
        end
        else
        begin
            col_next = col_ext[INDEX_BITS-1:0];
        end
        if (row_ovf)
        begin
            row_next = {row_ext[SW-1], {(INDEX_BITS-1){!row_ext[SW-1]}}};
        end
        else
        begin
            row_next = row_ext[INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            col1_reg <= col_next;
            row1_reg <= row_next;
            px1_reg  <= px;
            py1_reg  <= py;
        end
    end

    // stage 2: center minus point, center saturation
    always_comb
    begin
        dx_next = DXW'(cx_reg) - DXW'(px1_reg);
        dy_next = DXW'(cy_reg) - DXW'(py1_reg);
        cx_ovf  = cx_reg[CW-1:COORD_BITS-1] != {(CW-COORD_BITS+1){cx_reg[CW-1]}};
        cy_ovf  = cy_reg[CW-1:COORD_BITS-1] != {(CW-COORD_BITS+1){cy_reg[CW-1]}};
        if (cx_ovf)
        begin
            cxs_next = {cx_reg[CW-1], {(COORD_BITS-1){!cx_reg[CW-1]}}};
        end
        else
        begin
            cxs_next = cx_reg[COORD_BITS-1:0];
        end
        if (cy_ovf)
        begin
            cys_next = {cy_reg[CW-1], {(COORD_BITS-1){!cy_reg[CW-1]}}};
        end
        else
        begin
            cys_next = cy_reg[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            cxs_reg  <= cxs_next;
            cys_reg  <= cys_next;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];
    assign col_sat   = col2_reg;
    assign row_sat   = row2_reg;
    assign cx_sat    = cxs_reg;
    assign cy_sat    = cys_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hcl_dist.sv
// squared distance check and output register, three stages
`timescale 1ns / 1ps
`default_nettype none
`include "hex_cell_center_locator_unit_macros.svh"

module hcl_dist #(
    parameter int COORD_BITS = hcl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hcl_pkg::FRAC_BITS_DEF,
    localparam int DXW = hcl_pkg::delta_width(COORD_BITS, FRAC_BITS)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hcl_pkg::hcl_cfg_t                    cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [hcl_pkg::INDEX_BITS-1:0] col_sat,
    input  logic signed [hcl_pkg::INDEX_BITS-1:0] row_sat,
    input  logic signed [COORD_BITS-1:0]         cx_sat,
    input  logic signed [COORD_BITS-1:0]         cy_sat,
    input  logic signed [DXW-1:0]                dx,
    input  logic signed [DXW-1:0]                dy,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hcl_pkg::INDEX_BITS-1:0] cell_col,
    output logic signed [hcl_pkg::INDEX_BITS-1:0] cell_row,
    output logic signed [COORD_BITS-1:0]         center_x,
    output logic signed [COORD_BITS-1:0]         center_y,
    output logic                                 too_far
);
    import hcl_pkg::*;

    localparam int STAGES = 3;

    logic [STAGES-1:0] v_reg, v_next, adv;

    logic [DXW-1:0]               mx, my;
    logic [DIST_BITS-1:0]         ax_reg, ay_reg;
    logic [SQ_BITS-1:0]           sqx_reg, sqy_reg;
    logic                         big1_reg, big2_reg, big_next, far_reg, far_next;
    logic signed [INDEX_BITS-1:0] col_reg [STAGES];
    logic signed [INDEX_BITS-1:0] row_reg [STAGES];
    logic signed [COORD_BITS-1:0] cx_reg [STAGES];
    logic signed [COORD_BITS-1:0] cy_reg [STAGES];

    // bubble-collapsing advance chain
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                v_next[k] = (k == 0) ? in_valid : v_reg[k-1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // result fields ride along all three stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                col_reg[k] <= (k == 0) ? col_sat : col_reg[k-1];
                row_reg[k] <= (k == 0) ? row_sat : row_reg[k-1];
                cx_reg[k]  <= (k == 0) ? cx_sat  : cx_reg[k-1];
                cy_reg[k]  <= (k == 0) ? cy_sat  : cy_reg[k-1];
            end
        end
    end

    // stage 1: magnitudes, far flag for any component past the square range
    always_comb
    begin
        mx       = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
        my       = dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
        big_next = (|mx[DXW-1:DIST_BITS]) || (|my[DXW-1:DIST_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ax_reg   <= mx[DIST_BITS-1:0];
            ay_reg   <= my[DIST_BITS-1:0];
            big1_reg <= big_next;
        end
    end

    // stage 2: squares
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sqx_reg  <= SQ_BITS'(ax_reg) * SQ_BITS'(ax_reg);
            sqy_reg  <= SQ_BITS'(ay_reg) * SQ_BITS'(ay_reg);
            big2_reg <= big1_reg;
        end
    end

    // stage 3: sum against size squared
    always_comb
    begin
        far_next = big2_reg
            || ((SQ_BITS + 1)'(sqx_reg) + (SQ_BITS + 1)'(sqy_reg)
                > (SQ_BITS + 1)'(cfg.size_squared));
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            far_reg <= far_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];
    assign cell_col  = col_reg[STAGES-1];
    assign cell_row  = row_reg[STAGES-1];
    assign center_x  = cx_reg[STAGES-1];
    assign center_y  = cy_reg[STAGES-1];
    assign too_far   = far_reg;

    `HCL_ASSERT_NOW(a_dist_full_on_stall, !in_ready, &v_reg, "distance stage stalls with a bubble")
    `HCL_ASSERT_NEXT(a_dist_moves, v_reg[0] && adv[1], v_reg[1], "distance word dropped")
    `HCL_ASSERT_NEXT(a_dist_big_far, v_reg[1] && big2_reg == 1'b0 && big1_reg && adv[1] && adv[2],
        big2_reg, "far flag not carried")
    `HCL_ASSERT_NEXT(a_dist_far_out, v_reg[2] && big2_reg && adv[2], too_far,
        "large offset did not raise too_far")

endmodule

`default_nettype wire

FILE: hw/rtl/hex_cell_center_locator_unit.sv
// top level of the hexagon cell center locator
//
//   channel  direction  handshake              word
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    point_x, point_y
//   out      out        out_valid / out_ready  cell_col, cell_row, center_x, center_y, too_far
//
// one word per cycle sustained while out_ready is high; the stages in order are:
// offset, tile multiply, classify, center multiply, delta, magnitude, square, compare
// every stage holds its own valid bit, so bubbles close up while the output is stalled
// in_ready drops only when all eight stages hold words and out_ready is low
// rst_n clears the valid bits and the register file; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module hex_cell_center_locator_unit #(
    parameter int COORD_BITS = hcl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = hcl_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [hcl_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [hcl_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [COORD_BITS-1:0]            point_x,
    input  logic signed [COORD_BITS-1:0]            point_y,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [hcl_pkg::INDEX_BITS-1:0]   cell_col,
    output logic signed [hcl_pkg::INDEX_BITS-1:0]   cell_row,
    output logic signed [COORD_BITS-1:0]            center_x,
    output logic signed [COORD_BITS-1:0]            center_y,
    output logic                                    too_far
);
    import hcl_pkg::*;

    localparam int IW  = idx_width(COORD_BITS, FRAC_BITS);
    localparam int DXW = delta_width(COORD_BITS, FRAC_BITS);

    hcl_cfg_t cfg_reg, cfg_next;

    logic                         t_valid, t_ready, c_valid, c_ready;
    logic signed [IW-1:0]         t_icol, t_irow;
    logic signed [COORD_BITS-1:0] t_px, t_py;
    logic signed [INDEX_BITS-1:0] c_col, c_row;
    logic signed [COORD_BITS-1:0] c_cx, c_cy;
    logic signed [DXW-1:0]        c_dx, c_dy;

    // register file writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (hcl_cfg_idx_t'(cfg_index))
                CFG_COLUMN_PITCH:       cfg_next.column_pitch       = cfg_data[PITCH_BITS-1:0];
                CFG_ROW_PITCH:          cfg_next.row_pitch          = cfg_data[PITCH_BITS-1:0];
                CFG_INV_TILE_WIDTH:     cfg_next.inv_tile_width     = cfg_data[INV_BITS-1:0];
                CFG_INV_TILE_HEIGHT:    cfg_next.inv_tile_height    = cfg_data[INV_BITS-1:0];
                CFG_HALF_DOMAIN_WIDTH:  cfg_next.half_domain_width  = cfg_data[PITCH_BITS-1:0];
                CFG_HALF_DOMAIN_HEIGHT: cfg_next.half_domain_height = cfg_data[PITCH_BITS-1:0];
                CFG_SIZE_SQUARED:       cfg_next.size_squared       = cfg_data[SQ_BITS-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // tile scaling and classification
    hcl_tile #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_tile (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .icol      (t_icol),
        .irow      (t_irow),
        .px        (t_px),
        .py        (t_py)
    );

    // cell center
    hcl_center #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_center (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .icol      (t_icol),
        .irow      (t_irow),
        .px        (t_px),
        .py        (t_py),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .col_sat   (c_col),
        .row_sat   (c_row),
        .cx_sat    (c_cx),
        .cy_sat    (c_cy),
        .dx        (c_dx),
        .dy        (c_dy)
    );

    // distance check and output register
    hcl_dist #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .col_sat   (c_col),
        .row_sat   (c_row),
        .cx_sat    (c_cx),
        .cy_sat    (c_cy),
        .dx        (c_dx),
        .dy        (c_dy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .center_x  (center_x),
        .center_y  (center_y),
        .too_far   (too_far)
    );

endmodule

`default_nettype wire
